// ----- src/getb_pkg.sv -----
package getb_pkg;

  // Widths fixed by the request and result fields.
  localparam int CITY_W = 8;
  localparam int NODE_CNT_W = 9;
  localparam int DEG_W = 2;

  // Defaults and constants of the tour builder.
  localparam int DEF_MAX_CITIES = 256;
  localparam int RESET_NODE_COUNT = 256;
  localparam int MIN_NODE_COUNT = 3;
  localparam logic [DEG_W-1:0] DEG_ONE = 2'd1;
  localparam logic [DEG_W-1:0] DEG_FULL = 2'd2;

  // Request command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_FIND_B,
    ST_DECIDE,
    ST_WR_B,
    ST_RESP,
    ST_SCAN
  } state_t;

endpackage

// ----- src/greedy_edge_tour_builder_unit.sv -----
// Greedy-edge tour builder. Each request either starts a new tour (cmd 0, no result) or
// offers one candidate edge (cmd 1), and edges must arrive sorted by ascending length. An
// edge is taken when both cities have degree below two and lie in different components;
// every edge request gives one result, and the edge that completes n_eff-1 taken edges
// gives a second one, the closing edge between the two cities of degree one (lower city
// first). Per-city degrees and the union-find parent links live in two memories with a
// registered read. An edge walks the parent links from each city to its root in ST_FIND_A
// and ST_FIND_B, so the depth of the union-find trees sets the time. The edge that
// completes the tour adds a scan of the degree memory, one city per cycle, that stops at
// the second city of degree one. A start request, a node_count write and reset each run a
// clearing pass over every entry of both memories, during which no request is taken;
// configuration writes are taken at any time. A finished result waits in an output register.
module greedy_edge_tour_builder_unit #(
  parameter int MAX_CITIES = getb_pkg::DEF_MAX_CITIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: node_count
  input  logic                            cfg_we,
  input  logic [getb_pkg::NODE_CNT_W-1:0] cfg_wdata,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [getb_pkg::CITY_W-1:0]     in_city_a,
  input  logic [getb_pkg::CITY_W-1:0]     in_city_b,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [getb_pkg::CITY_W-1:0]     out_edge_from,
  output logic [getb_pkg::CITY_W-1:0]     out_edge_to,
  output logic                            out_closing,
  output logic                            out_bad_edge,
  output logic                            out_tour_done,
  output logic                            out_last
);

  localparam int CW = $clog2(MAX_CITIES);
  localparam int DW = getb_pkg::DEG_W;
  localparam int AW = getb_pkg::CITY_W;
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_CITIES - 1);

  // Degree and parent memories, one entry per city.
  logic [DW-1:0] deg_mem [MAX_CITIES];
  logic [CW-1:0] par_mem [MAX_CITIES];

  logic [DW-1:0] deg_rd_r;
  logic [CW-1:0] par_rd_r;
  logic [CW-1:0] rd_addr;

  logic          deg_we;
  logic [CW-1:0] deg_waddr;
  logic [DW-1:0] deg_wdata;
  logic          par_we;
  logic [CW-1:0] par_waddr;
  logic [CW-1:0] par_wdata;

  getb_pkg::state_t state_r, state_nxt;

  logic [getb_pkg::NODE_CNT_W-1:0] node_count_r, node_count_nxt;
  logic [CW:0]   n_eff;

  logic [CW-1:0] clr_idx_r, clr_idx_nxt;
  logic [CW:0]   edges_r, edges_nxt;
  logic          done_r, done_nxt;

  logic [AW-1:0] city_a_r, city_a_nxt;
  logic [AW-1:0] city_b_r, city_b_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic          first_r, first_nxt;
  logic [DW-1:0] deg_a_r, deg_a_nxt;
  logic [DW-1:0] deg_b_r, deg_b_nxt;
  logic [CW-1:0] root_a_r, root_a_nxt;
  logic [CW-1:0] root_b_r, root_b_nxt;

  logic [CW:0]   scan_idx_r, scan_idx_nxt;
  logic          scan_v_r, scan_v_nxt;
  logic [CW-1:0] scan_at_r, scan_at_nxt;
  logic [1:0]    found_r, found_nxt;
  logic [CW-1:0] end0_r, end0_nxt;
  logic [CW-1:0] end1_r, end1_nxt;

  // Staged result, handed to the output register in ST_RESP.
  logic          more_r, more_nxt;
  logic          res_acc_r, res_acc_nxt;
  logic [AW-1:0] res_from_r, res_from_nxt;
  logic [AW-1:0] res_to_r, res_to_nxt;
  logic          res_clo_r, res_clo_nxt;
  logic          res_bad_r, res_bad_nxt;
  logic          res_done_r, res_done_nxt;
  logic          res_last_r, res_last_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_acc_r, out_acc_nxt;
  logic [AW-1:0] out_from_r, out_from_nxt;
  logic [AW-1:0] out_to_r, out_to_nxt;
  logic          out_clo_r, out_clo_nxt;
  logic          out_bad_r, out_bad_nxt;
  logic          out_done_r, out_done_nxt;
  logic          out_last_r, out_last_nxt;

  // Effective city count: node_count saturated to 3..MAX_CITIES.
  always_comb begin
    logic [31:0] nc;
    nc = 32'(node_count_r);
    if (nc < 32'(getb_pkg::MIN_NODE_COUNT)) begin
      nc = 32'(getb_pkg::MIN_NODE_COUNT);
    end else if (nc > 32'(MAX_CITIES)) begin
      nc = 32'(MAX_CITIES);
    end
    n_eff = nc[CW:0];
  end

  always_comb begin
    logic [31:0]   in_a_ext;
    logic [31:0]   in_b_ext;
    logic [31:0]   a_ext;
    logic [31:0]   b_ext;
    logic [31:0]   b_idx_ext;
    logic [31:0]   end0_ext;
    logic [31:0]   end1_ext;
    logic          in_bad;
    logic          out_free;
    logic          issue;
    logic          hit;
    logic [CW:0]   edges_inc;

    in_a_ext  = 32'(in_city_a);
    in_b_ext  = 32'(in_city_b);
    a_ext     = 32'(city_a_r);
    b_ext     = 32'(city_b_r);
    b_idx_ext = 32'(city_b_r);
    end0_ext  = 32'(end0_r);
    end1_ext  = 32'(end1_r);
    in_bad    = (in_a_ext >= 32'(n_eff)) || (in_b_ext >= 32'(n_eff)) ||
                (in_city_a == in_city_b);
    out_free  = !out_valid_r || out_ready;
    issue     = scan_idx_r < n_eff;
    hit       = scan_v_r && (deg_rd_r == getb_pkg::DEG_ONE) && (found_r < 2'd2);
    edges_inc = edges_r + 1'b1;

    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    clr_idx_nxt    = clr_idx_r;
    edges_nxt      = edges_r;
    done_nxt       = done_r;
    city_a_nxt     = city_a_r;
    city_b_nxt     = city_b_r;
    cur_nxt        = cur_r;
    first_nxt      = first_r;
    deg_a_nxt      = deg_a_r;
    deg_b_nxt      = deg_b_r;
    root_a_nxt     = root_a_r;
    root_b_nxt     = root_b_r;
    scan_idx_nxt   = scan_idx_r;
    scan_v_nxt     = 1'b0;
    scan_at_nxt    = scan_at_r;
    found_nxt      = found_r;
    end0_nxt       = end0_r;
    end1_nxt       = end1_r;
    more_nxt       = more_r;
    res_acc_nxt    = res_acc_r;
    res_from_nxt   = res_from_r;
    res_to_nxt     = res_to_r;
    res_clo_nxt    = res_clo_r;
    res_bad_nxt    = res_bad_r;
    res_done_nxt   = res_done_r;
    res_last_nxt   = res_last_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_acc_nxt   = out_acc_r;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_clo_nxt   = out_clo_r;
    out_bad_nxt   = out_bad_r;
    out_done_nxt  = out_done_r;
    out_last_nxt  = out_last_r;

    in_ready  = 1'b0;
    rd_addr   = cur_r;
    deg_we    = 1'b0;
    deg_waddr = clr_idx_r;
    deg_wdata = '0;
    par_we    = 1'b0;
    par_waddr = clr_idx_r;
    par_wdata = clr_idx_r;

    unique case (state_r)
      getb_pkg::ST_CLEAR: begin
        // Every city back to degree zero and its own root.
        deg_we      = 1'b1;
        par_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = getb_pkg::ST_IDLE;
        end
      end

      getb_pkg::ST_IDLE: begin
        in_ready   = !cfg_we;
        rd_addr    = in_a_ext[CW-1:0];
        cur_nxt    = in_a_ext[CW-1:0];
        first_nxt  = 1'b1;
        city_a_nxt = in_city_a;
        city_b_nxt = in_city_b;
        if (in_valid && !cfg_we) begin
          if (in_cmd == getb_pkg::CMD_START) begin
            clr_idx_nxt = '0;
            edges_nxt   = '0;
            done_nxt    = 1'b0;
            state_nxt   = getb_pkg::ST_CLEAR;
          end else if (done_r || in_bad) begin
            // Ignored or malformed edge: the state stays as it is.
            res_acc_nxt  = 1'b0;
            res_from_nxt = in_city_a;
            res_to_nxt   = in_city_b;
            res_clo_nxt  = 1'b0;
            res_bad_nxt  = in_bad;
            res_done_nxt = done_r;
            res_last_nxt = 1'b1;
            more_nxt     = 1'b0;
            state_nxt    = getb_pkg::ST_RESP;
          end else begin
            state_nxt = getb_pkg::ST_FIND_A;
          end
        end
      end

      getb_pkg::ST_FIND_A: begin
        // Read data belongs to cur_r; follow parent links until a self link.
        if (first_r) begin
          deg_a_nxt = deg_rd_r;
        end
        first_nxt = 1'b0;
        if (par_rd_r == cur_r) begin
          root_a_nxt = cur_r;
          rd_addr    = b_idx_ext[CW-1:0];
          cur_nxt    = b_idx_ext[CW-1:0];
          first_nxt  = 1'b1;
          state_nxt  = getb_pkg::ST_FIND_B;
        end else begin
          rd_addr = par_rd_r;
          cur_nxt = par_rd_r;
        end
      end

      getb_pkg::ST_FIND_B: begin
        if (first_r) begin
          deg_b_nxt = deg_rd_r;
        end
        first_nxt = 1'b0;
        if (par_rd_r == cur_r) begin
          root_b_nxt = cur_r;
          state_nxt  = getb_pkg::ST_DECIDE;
        end else begin
          rd_addr = par_rd_r;
          cur_nxt = par_rd_r;
        end
      end

      getb_pkg::ST_DECIDE: begin
        res_from_nxt = city_a_r;
        res_to_nxt   = city_b_r;
        res_clo_nxt  = 1'b0;
        res_bad_nxt  = 1'b0;
        res_done_nxt = 1'b0;
        if (deg_a_r >= getb_pkg::DEG_FULL || deg_b_r >= getb_pkg::DEG_FULL ||
            root_a_r == root_b_r) begin
          res_acc_nxt  = 1'b0;
          res_last_nxt = 1'b1;
          more_nxt     = 1'b0;
          state_nxt    = getb_pkg::ST_RESP;
        end else begin
          // Take the edge: bump city a and hang root a under root b.
          deg_we    = 1'b1;
          deg_waddr = a_ext[CW-1:0];
          deg_wdata = deg_a_r + 1'b1;
          par_we    = 1'b1;
          par_waddr = root_a_r;
          par_wdata = root_b_r;
          state_nxt = getb_pkg::ST_WR_B;
        end
      end

      getb_pkg::ST_WR_B: begin
        deg_we       = 1'b1;
        deg_waddr    = b_ext[CW-1:0];
        deg_wdata    = deg_b_r + 1'b1;
        edges_nxt    = edges_inc;
        res_acc_nxt  = 1'b1;
        // The edge that leaves one more to go brings the closing edge after it.
        more_nxt     = (32'(edges_inc) + 32'd1) == 32'(n_eff);
        res_last_nxt = !((32'(edges_inc) + 32'd1) == 32'(n_eff));
        state_nxt    = getb_pkg::ST_RESP;
      end

      getb_pkg::ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_from_nxt  = res_from_r;
          out_to_nxt    = res_to_r;
          out_clo_nxt   = res_clo_r;
          out_bad_nxt   = res_bad_r;
          out_done_nxt  = res_done_r;
          out_last_nxt  = res_last_r;
          if (more_r) begin
            scan_idx_nxt = '0;
            found_nxt    = '0;
            end0_nxt     = '0;
            end1_nxt     = '0;
            state_nxt    = getb_pkg::ST_SCAN;
          end else begin
            state_nxt = getb_pkg::ST_IDLE;
          end
        end
      end

      getb_pkg::ST_SCAN: begin
        // One read issued per cycle; scan_at_r is registered with the read, so it names the city in deg_rd_r.
        rd_addr     = scan_idx_r[CW-1:0];
        scan_v_nxt  = issue;
        scan_at_nxt = scan_idx_r[CW-1:0];
        if (issue) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (hit) begin
          found_nxt = found_r + 1'b1;
          if (found_r == 2'd0) begin
            end0_nxt = scan_at_r;
          end else begin
            end1_nxt = scan_at_r;
          end
        end
        if ((hit && found_r == 2'd1) || (!issue && !scan_v_r)) begin
          res_acc_nxt  = 1'b1;
          res_from_nxt = (hit && found_r == 2'd0) ? AW'(32'(scan_at_r)) : end0_ext[AW-1:0];
          res_to_nxt   = hit ? AW'(32'(scan_at_r)) : end1_ext[AW-1:0];
          res_clo_nxt  = 1'b1;
          res_bad_nxt  = 1'b0;
          res_done_nxt = 1'b1;
          res_last_nxt = 1'b1;
          more_nxt     = 1'b0;
          done_nxt     = 1'b1;
          state_nxt    = getb_pkg::ST_RESP;
        end
      end
    endcase

    // A node_count write restarts the tour from a clean state.
    if (cfg_we) begin
      node_count_nxt = cfg_wdata;
      clr_idx_nxt    = '0;
      edges_nxt      = '0;
      done_nxt       = 1'b0;
      state_nxt      = getb_pkg::ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= getb_pkg::ST_CLEAR;
      node_count_r <= getb_pkg::NODE_CNT_W'(getb_pkg::RESET_NODE_COUNT);
      clr_idx_r    <= '0;
      edges_r      <= '0;
      done_r       <= 1'b0;
      first_r      <= 1'b0;
      scan_v_r     <= 1'b0;
      found_r      <= '0;
      more_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      clr_idx_r    <= clr_idx_nxt;
      edges_r      <= edges_nxt;
      done_r       <= done_nxt;
      first_r      <= first_nxt;
      scan_v_r     <= scan_v_nxt;
      found_r      <= found_nxt;
      more_r       <= more_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    city_a_r   <= city_a_nxt;
    city_b_r   <= city_b_nxt;
    cur_r      <= cur_nxt;
    deg_a_r    <= deg_a_nxt;
    deg_b_r    <= deg_b_nxt;
    root_a_r   <= root_a_nxt;
    root_b_r   <= root_b_nxt;
    scan_idx_r <= scan_idx_nxt;
    scan_at_r  <= scan_at_nxt;
    end0_r     <= end0_nxt;
    end1_r     <= end1_nxt;
    res_acc_r  <= res_acc_nxt;
    res_from_r <= res_from_nxt;
    res_to_r   <= res_to_nxt;
    res_clo_r  <= res_clo_nxt;
    res_bad_r  <= res_bad_nxt;
    res_done_r <= res_done_nxt;
    res_last_r <= res_last_nxt;
    out_acc_r  <= out_acc_nxt;
    out_from_r <= out_from_nxt;
    out_to_r   <= out_to_nxt;
    out_clo_r  <= out_clo_nxt;
    out_bad_r  <= out_bad_nxt;
    out_done_r <= out_done_nxt;
    out_last_r <= out_last_nxt;
  end

  // Memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_rd_r <= deg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rd_r <= par_mem[rd_addr];
  end

  assign out_valid     = out_valid_r;
  assign out_accepted  = out_acc_r;
  assign out_edge_from = out_from_r;
  assign out_edge_to   = out_to_r;
  assign out_closing   = out_clo_r;
  assign out_bad_edge  = out_bad_r;
  assign out_tour_done = out_done_r;
  assign out_last      = out_last_r;

endmodule

// ----- tb/testbench.sv -----
module testbench;

  // Cycles of quiet time before a node_count write and at the end of the run. The
  // longest silent stretch of the block is a clearing pass after a start request, or the
  // degree scan of a closing edge, so this leaves ample margin.
  localparam int SETTLE_CYCLES = 600;
  // Long hold-off of the result side, used once to back the block up into its input.
  localparam int HOLD_CYCLES = 400;
  // Cycles with no handshake on either channel before the run is declared hung. A deep
  // union-find walk on both cities, a clearing pass and the hold-off each stay well below it.
  localparam int STUCK_LIMIT = 20000;

  // One result of the block, as it appears on the result channel.
  typedef struct packed {
    logic                        accepted;
    logic [getb_pkg::CITY_W-1:0] edge_from;
    logic [getb_pkg::CITY_W-1:0] edge_to;
    logic                        closing;
    logic                        bad_edge;
    logic                        tour_done;
    logic                        last;
  } tour_result_t;

  // Directed table: what each row does, and the outcome typed in for rows whose result is
  // obvious. Rows marked PIN_NONE take their expectation from the predictor.
  typedef enum {RQ_START, RQ_EDGE, RQ_WRITE} plan_kind_t;
  typedef enum {PIN_NONE, PIN_TAKEN, PIN_REJECT, PIN_BAD, PIN_LATE, PIN_LATE_BAD} edge_pin_t;

  typedef struct {
    plan_kind_t  kind;
    int unsigned a;
    int unsigned b;
    edge_pin_t   pin;
  } plan_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [getb_pkg::NODE_CNT_W-1:0] cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_cmd = getb_pkg::CMD_START;
  logic [getb_pkg::CITY_W-1:0]     in_city_a = '0;
  logic [getb_pkg::CITY_W-1:0]     in_city_b = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_accepted;
  logic [getb_pkg::CITY_W-1:0]     out_edge_from;
  logic [getb_pkg::CITY_W-1:0]     out_edge_to;
  logic                            out_closing;
  logic                            out_bad_edge;
  logic                            out_tour_done;
  logic                            out_last;

  always #1 clk = ~clk;

  greedy_edge_tour_builder_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_city_a    (in_city_a),
    .in_city_b    (in_city_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_accepted (out_accepted),
    .out_edge_from(out_edge_from),
    .out_edge_to  (out_edge_to),
    .out_closing  (out_closing),
    .out_bad_edge (out_bad_edge),
    .out_tour_done(out_tour_done),
    .out_last     (out_last)
  );

  // ---------------------------------------------------------------------------------------
  // Tour predictor. It mirrors the block's state: the node_count register, the degree of
  // every city, the union-find parent links, the count of taken edges and the done flag.
  // ---------------------------------------------------------------------------------------
  logic [getb_pkg::NODE_CNT_W-1:0] nc_reg;
  logic [getb_pkg::DEG_W-1:0]      deg_of    [getb_pkg::DEF_MAX_CITIES];
  logic [getb_pkg::CITY_W-1:0]     root_link [getb_pkg::DEF_MAX_CITIES];
  logic [getb_pkg::NODE_CNT_W-1:0] taken_cnt;
  logic                            tour_over;

  // Results that the block still owes, oldest first.
  tour_result_t tour_results_due[$];

  int  mismatches = 0;
  int  requests_sent = 0;
  int  gap_pct = 0;
  int  stall_pct = 0;
  bit  quiet = 1'b0;
  bit  press_hold = 1'b0;

  // Appends a result to the owed list.
  function automatic void owe_result(input tour_result_t r);
    tour_results_due.insert(tour_results_due.size(), r);
  endfunction

  // Forgets the most recently owed result.
  function automatic void drop_newest_result();
    tour_results_due.delete(tour_results_due.size() - 1);
  endfunction

  // The city count in force: node_count saturated to the range the block supports.
  function automatic int unsigned city_span();
    int unsigned n;
    n = 32'(nc_reg);
    if (n < getb_pkg::MIN_NODE_COUNT) n = getb_pkg::MIN_NODE_COUNT;
    if (n > getb_pkg::DEF_MAX_CITIES) n = getb_pkg::DEF_MAX_CITIES;
    return n;
  endfunction

  // A start request, a node_count write and reset all forget the tour built so far.
  function automatic void wipe_tour();
    for (int i = 0; i < getb_pkg::DEF_MAX_CITIES; i++) begin
      deg_of[i] = '0;
      root_link[i] = getb_pkg::CITY_W'(i);
    end
    taken_cnt = '0;
    tour_over = 1'b0;
  endfunction

  function automatic logic [getb_pkg::CITY_W-1:0] root_of(
      input logic [getb_pkg::CITY_W-1:0] c);
    logic [getb_pkg::CITY_W-1:0] p;
    for (int s = 0; s < getb_pkg::DEF_MAX_CITIES; s++) begin
      p = root_link[c];
      if (p == c) break;
      c = p;
    end
    return c;
  endfunction

  // Decides an offered edge, updates the tour and queues the one or two results it causes.
  function automatic void judge_edge(input logic [getb_pkg::CITY_W-1:0] a,
                                     input logic [getb_pkg::CITY_W-1:0] b);
    int unsigned                 n;
    int                          found;
    logic                        bad;
    logic [getb_pkg::CITY_W-1:0] ra;
    logic [getb_pkg::CITY_W-1:0] rb;
    logic [getb_pkg::CITY_W-1:0] e0;
    logic [getb_pkg::CITY_W-1:0] e1;
    tour_result_t                r;
    n = city_span();
    bad = (a >= n) || (b >= n) || (a == b);
    r = '0;
    r.edge_from = a;
    r.edge_to = b;
    r.last = 1'b1;
    // Once the tour is closed every edge is only echoed back, and a bad one is still flagged.
    if (tour_over || bad) begin
      r.bad_edge = bad;
      r.tour_done = tour_over;
      owe_result(r);
      return;
    end
    ra = root_of(a);
    rb = root_of(b);
    if (deg_of[a] >= getb_pkg::DEG_FULL || deg_of[b] >= getb_pkg::DEG_FULL || ra == rb) begin
      owe_result(r);
      return;
    end
    deg_of[a] = deg_of[a] + 2'd1;
    deg_of[b] = deg_of[b] + 2'd1;
    root_link[ra] = rb;
    taken_cnt = taken_cnt + 1'b1;
    r.accepted = 1'b1;
    if (taken_cnt + 1 != n) begin
      owe_result(r);
      return;
    end
    // This edge completes the path; the closing edge joins its two ends, lower city first.
    r.last = 1'b0;
    owe_result(r);
    e0 = '0;
    e1 = '0;
    found = 0;
    for (int i = 0; i < n && found < 2; i++) begin
      if (deg_of[i] == getb_pkg::DEG_ONE) begin
        if (found == 0) e0 = getb_pkg::CITY_W'(i);
        else e1 = getb_pkg::CITY_W'(i);
        found++;
      end
    end
    if (found > 0) deg_of[e0] = getb_pkg::DEG_FULL;
    if (found > 1) deg_of[e1] = getb_pkg::DEG_FULL;
    taken_cnt = taken_cnt + 1'b1;
    tour_over = 1'b1;
    r = '0;
    r.accepted = 1'b1;
    r.edge_from = e0;
    r.edge_to = e1;
    r.closing = 1'b1;
    r.tour_done = 1'b1;
    r.last = 1'b1;
    owe_result(r);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Request side. A request is presented at a clock edge and held, unchanged, until the
  // block takes it. Between requests the sender may idle for a random burst of cycles.
  // ---------------------------------------------------------------------------------------
  task automatic drive_request(input logic cmd, input logic [getb_pkg::CITY_W-1:0] a,
                               input logic [getb_pkg::CITY_W-1:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_city_a <= a;
    in_city_b <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Offers one edge. Where the table pins the outcome, the predictor still tracks the
  // state, but its result is swapped for the one typed into the table.
  task automatic offer_edge(input logic [getb_pkg::CITY_W-1:0] a,
                            input logic [getb_pkg::CITY_W-1:0] b,
                            input edge_pin_t pin);
    int           mark;
    tour_result_t r;
    drive_request(getb_pkg::CMD_EDGE, a, b);
    mark = tour_results_due.size();
    judge_edge(a, b);
    if (pin != PIN_NONE) begin
      while (tour_results_due.size() > mark) drop_newest_result();
      r = '0;
      r.edge_from = a;
      r.edge_to = b;
      r.last = 1'b1;
      case (pin)
        PIN_TAKEN: r.accepted = 1'b1;
        PIN_BAD: r.bad_edge = 1'b1;
        PIN_LATE: r.tour_done = 1'b1;
        PIN_LATE_BAD: begin
          r.bad_edge = 1'b1;
          r.tour_done = 1'b1;
        end
        default: ;
      endcase
      owe_result(r);
    end
    requests_sent++;
  endtask

  // A start request carries city fields too; they are meaningless, so they get junk.
  task automatic offer_start(input logic [getb_pkg::CITY_W-1:0] a,
                             input logic [getb_pkg::CITY_W-1:0] b);
    drive_request(getb_pkg::CMD_START, a, b);
    wipe_tour();
    requests_sent++;
  endtask

  // Lets the block drain: no request is offered, every owed result must arrive, and then
  // the block gets time to finish a clearing pass that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (tour_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(input logic [getb_pkg::NODE_CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    nc_reg = value;
    wipe_tour();
  endtask

  plan_row_t plan[$];

  function automatic void plan_add(input plan_kind_t kind, input int unsigned a,
                                   input int unsigned b, input edge_pin_t pin);
    plan_row_t row;
    row.kind = kind;
    row.a = a;
    row.b = b;
    row.pin = pin;
    plan.insert(plan.size(), row);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Main stimulus: reset, the directed table, then random phases at several city counts.
  // ---------------------------------------------------------------------------------------
  initial begin
    int unsigned phase_nc[$];
    int unsigned phase_quota[$];
    int unsigned perm[getb_pkg::DEF_MAX_CITIES];
    int unsigned order[getb_pkg::DEF_MAX_CITIES];
    int unsigned n;
    int unsigned tmp;
    int          phase_items;
    int          idx;
    int          guard;
    int          abandon_at;
    int          perm_pct;
    int          late;
    int          r;
    int          j;
    logic [getb_pkg::CITY_W-1:0] a;
    logic [getb_pkg::CITY_W-1:0] b;

    nc_reg = getb_pkg::NODE_CNT_W'(getb_pkg::RESET_NODE_COUNT);
    wipe_tour();

    // After reset the block holds 256 cities. Equal cities and the top city paired with
    // itself are bad; a fresh edge is taken; its reverse closes a loop and is refused.
    plan_add(RQ_EDGE, 0, 0, PIN_BAD);
    plan_add(RQ_EDGE, 255, 255, PIN_BAD);
    plan_add(RQ_EDGE, 0, 255, PIN_TAKEN);
    plan_add(RQ_EDGE, 255, 0, PIN_REJECT);
    plan_add(RQ_EDGE, 0, 1, PIN_TAKEN);
    // City 0 now has full degree (DEG_FULL), so a further edge on it is refused.
    plan_add(RQ_EDGE, 0, 2, PIN_REJECT);
    // A start request wipes the tour, so the first edge is taken again.
    plan_add(RQ_START, 170, 85, PIN_NONE);
    plan_add(RQ_EDGE, 0, 255, PIN_TAKEN);
    // Smallest tour: three cities, so city 3 and above are out of range.
    plan_add(RQ_WRITE, 3, 0, PIN_NONE);
    plan_add(RQ_EDGE, 0, 3, PIN_BAD);
    plan_add(RQ_EDGE, 2, 255, PIN_BAD);
    plan_add(RQ_EDGE, 0, 1, PIN_TAKEN);
    // The second taken edge completes the path and brings the closing edge with it.
    plan_add(RQ_EDGE, 1, 2, PIN_NONE);
    // With the tour closed, edges are echoed as done, and bad ones are still flagged.
    plan_add(RQ_EDGE, 0, 2, PIN_LATE);
    plan_add(RQ_EDGE, 0, 0, PIN_LATE_BAD);
    plan_add(RQ_EDGE, 7, 200, PIN_LATE_BAD);
    plan_add(RQ_START, 85, 170, PIN_NONE);
    plan_add(RQ_EDGE, 2, 1, PIN_TAKEN);
    // A node_count of zero saturates to three cities, and the write clears the tour.
    plan_add(RQ_WRITE, 0, 0, PIN_NONE);
    plan_add(RQ_EDGE, 2, 0, PIN_TAKEN);
    plan_add(RQ_EDGE, 0, 1, PIN_NONE);
    // The largest register value saturates to the full city count.
    plan_add(RQ_WRITE, 511, 0, PIN_NONE);
    plan_add(RQ_EDGE, 255, 254, PIN_TAKEN);
    plan_add(RQ_EDGE, 128, 127, PIN_TAKEN);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      case (plan[i].kind)
        RQ_START: offer_start(getb_pkg::CITY_W'(plan[i].a), getb_pkg::CITY_W'(plan[i].b));
        RQ_EDGE: offer_edge(getb_pkg::CITY_W'(plan[i].a), getb_pkg::CITY_W'(plan[i].b),
                            plan[i].pin);
        default: begin
          settle();
          write_node_count(getb_pkg::NODE_CNT_W'(plan[i].a));
        end
      endcase
    end

    // Random phases. Most use small city counts; one builds a full 256-city tour, and two
    // values above the limit check saturation without finishing a tour.
    phase_nc = '{2, 256, 1, $urandom_range(5, 9), 3, $urandom_range(257, 510),
                 $urandom_range(10, 20), 0, 511, $urandom_range(21, 40), 4};
    phase_quota = '{100, 320, 90, 150, 80, 50, 140, 60, 40, 120, 90};

    foreach (phase_nc[p]) begin
      settle();
      write_node_count(getb_pkg::NODE_CNT_W'(phase_nc[p]));
      n = city_span();
      gap_pct = $urandom_range(0, 40);
      stall_pct = $urandom_range(0, 25);
      // One phase starts with the result side held off for a long time while requests
      // keep coming, so that the block backs up and stalls its request channel.
      if (p == 3) press_hold = 1'b1;
      // The final phase runs with no idling on either side.
      if (p == phase_nc.size() - 1) quiet = 1'b1;
      phase_items = 0;

      while (phase_items < phase_quota[p]) begin
        // Each tour starts cleanly. Its edges are mostly the links of a random path through
        // all cities, in random order and orientation, mixed with random in-range edges
        // that hit the degree and component checks, and some raw noise.
        offer_start(getb_pkg::CITY_W'($urandom_range(0, 255)),
                    getb_pkg::CITY_W'($urandom_range(0, 255)));
        phase_items++;
        for (int i = 0; i < n; i++) perm[i] = i;
        for (int i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < n - 1; i++) order[i] = i;
        for (int i = n - 2; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        perm_pct = (n > 64) ? 92 : 65;
        // Some small tours are cut short by the next start request.
        abandon_at = (n <= 64 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n) : -1;
        idx = 0;
        guard = 0;
        while (!tour_over && phase_items < phase_quota[p] && guard < 4 * n + 20) begin
          if (guard == abandon_at) break;
          r = $urandom_range(0, 99);
          if (r < perm_pct && idx < n - 1) begin
            a = getb_pkg::CITY_W'(perm[order[idx]]);
            b = getb_pkg::CITY_W'(perm[order[idx] + 1]);
            idx++;
            if ($urandom_range(0, 1) == 1) begin
              tmp = 32'(a);
              a = b;
              b = getb_pkg::CITY_W'(tmp);
            end
          end else if (r < 94) begin
            a = getb_pkg::CITY_W'($urandom_range(0, n - 1));
            b = getb_pkg::CITY_W'($urandom_range(0, n - 1));
          end else begin
            a = getb_pkg::CITY_W'($urandom_range(0, 255));
            b = getb_pkg::CITY_W'($urandom_range(0, 255));
          end
          offer_edge(a, b, PIN_NONE);
          phase_items++;
          guard++;
        end
        // A few random edges after the tour; once it is closed, the block only echoes them back.
        late = $urandom_range(0, 3);
        while (late > 0 && phase_items < phase_quota[p]) begin
          offer_edge(getb_pkg::CITY_W'($urandom_range(0, 255)),
                     getb_pkg::CITY_W'($urandom_range(0, 255)), PIN_NONE);
          phase_items++;
          late--;
        end
      end
    end

    settle();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------------------
  // Result side. The receiver stalls in random bursts, and once for a long stretch.
  // ---------------------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (press_hold) begin
        press_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(input string name,
                                      input logic [getb_pkg::CITY_W-1:0] want,
                                      input logic [getb_pkg::CITY_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every result taken by the receiver is held against the oldest owed result.
  always @(posedge clk) begin
    tour_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tour_results_due.size() == 0) begin
        $display("%0t: expected no result, got accepted %0d edge %0d-%0d closing %0d bad %0d",
                 $time, out_accepted, out_edge_from, out_edge_to, out_closing, out_bad_edge);
        mismatches++;
      end else begin
        want = tour_results_due.pop_front();
        check_field("accepted", getb_pkg::CITY_W'(want.accepted),
                    getb_pkg::CITY_W'(out_accepted));
        check_field("edge_from", want.edge_from, out_edge_from);
        check_field("edge_to", want.edge_to, out_edge_to);
        check_field("closing", getb_pkg::CITY_W'(want.closing),
                    getb_pkg::CITY_W'(out_closing));
        check_field("bad_edge", getb_pkg::CITY_W'(want.bad_edge),
                    getb_pkg::CITY_W'(out_bad_edge));
        check_field("tour_done", getb_pkg::CITY_W'(want.tour_done),
                    getb_pkg::CITY_W'(out_tour_done));
        check_field("last", getb_pkg::CITY_W'(want.last), getb_pkg::CITY_W'(out_last));
      end
    end
  end

  // Hang detector: it counts cycles in which neither channel completes a handshake.
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stuck = 0;
      else stuck++;
    end
    $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
